// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication in the same cycle, outside reset
`define CHD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check an implication in the cycle after the antecedent, outside reset
`define CHD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/chd_pkg.sv =====
package chd_pkg;

	// Width of the chunk size counter
	localparam int SIZE_BITS = 32;
	localparam int TOTAL_W   = 32;
	localparam int MAX_W     = 31;

	// Configuration port
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_ADDR_W-1:0] REG_MAX_BODY = 3'd0;

	localparam logic [7:0] BYTE_CR = 8'h0D;
	localparam logic [7:0] BYTE_LF = 8'h0A;

	typedef enum logic [3:0] {
		PH_SIZE_FIRST,
		PH_SIZE_MORE,
		PH_SIZE_EXT,
		PH_SIZE_LF,
		PH_DATA,
		PH_DATA_CR,
		PH_DATA_LF,
		PH_END_CR,
		PH_END_LF,
		PH_DONE,
		PH_HALT
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK,
		ST_OVERFLOW,
		ST_FRAMING,
		ST_TOO_LARGE,
		ST_AFTER_END
	} status_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	// One decoded result item
	typedef struct packed {
		logic [7:0] out_byte;
		logic       payload_valid;
		logic       body_done;
		status_t    status;
	} res_t;

	// Control into the framing engine
	typedef struct packed {
		logic       step;
		logic [7:0] data;
	} step_t;

	// Status back from the framing engine
	typedef struct packed {
		status_t err;
		logic    fin;
		phase_t  phase;
	} frame_stat_t;

	// Decode one ASCII hex digit
	function automatic hex_t hex_value(input logic [7:0] b);
		hex_t h;
		h.ok  = 1'b1;
		h.val = 4'd0;
		if (b >= 8'h30 && b <= 8'h39) begin
			h.val = b[3:0];
		end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
			h.val = b[3:0] + 4'd9;
		end else begin
			h.ok = 1'b0;
		end
		return h;
	endfunction

endpackage

// ===== rtl/chd_if.sv =====
interface chd_raw_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

interface chd_dec_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       payload_valid;
	logic       body_done;
	logic [2:0] status;

	modport source (output valid, output out_byte, output payload_valid,
		output body_done, output status, input ready);
	modport sink (input valid, input out_byte, input payload_valid,
		input body_done, input status, output ready);
endinterface

// ===== rtl/chd_apb.sv =====
module chd_apb (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [chd_pkg::CFG_ADDR_W-1:0]     paddr,
	input  logic [chd_pkg::CFG_DATA_W-1:0]     pwdata,
	output logic [chd_pkg::CFG_DATA_W-1:0]     prdata,
	output logic                               pready,
	output logic [chd_pkg::MAX_W-1:0]          max_body_size
);

	logic [chd_pkg::MAX_W-1:0] max_q;
	logic                      wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && (paddr == chd_pkg::REG_MAX_BODY);

	// Capture the limit on the access phase of a write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= '0;
		end else if (wr_en) begin
			max_q <= pwdata[chd_pkg::MAX_W-1:0];
		end
	end

	// Read back; unmapped addresses return zero
	always_comb begin
		prdata = '0;
		if (paddr == chd_pkg::REG_MAX_BODY) begin
			prdata = {{(chd_pkg::CFG_DATA_W - chd_pkg::MAX_W){1'b0}}, max_q};
		end
	end

	assign max_body_size = max_q;

endmodule

// ===== rtl/chd_frame.sv =====
module chd_frame (
	input  logic                      clk,
	input  logic                      arst_n,
	input  chd_pkg::step_t            ctl,
	input  logic [chd_pkg::MAX_W-1:0] max_body_size,
	output chd_pkg::res_t             res,
	output chd_pkg::frame_stat_t      stat
);

	chd_pkg::phase_t                  phase_q, phase_d;
	chd_pkg::status_t                 err_q, err_d;
	logic                             fin_q, fin_d;
	logic [chd_pkg::SIZE_BITS-1:0]    remain_q, remain_d;
	logic [chd_pkg::TOTAL_W-1:0]      total_q, total_d;
	chd_pkg::hex_t                    h;
	logic                             too_large;
	logic [7:0]                       ob;
	logic                             pv;

	assign h = chd_pkg::hex_value(ctl.data);
	assign too_large = (max_body_size != '0) &&
		(total_q > {{(chd_pkg::TOTAL_W - chd_pkg::MAX_W){1'b0}}, max_body_size});

	// Next state and the result for the byte in hand
	always_comb begin
		phase_d  = phase_q;
		err_d    = err_q;
		fin_d    = fin_q;
		remain_d = remain_q;
		total_d  = total_q;
		ob       = 8'd0;
		pv       = 1'b0;
		case (phase_q)
			chd_pkg::PH_SIZE_FIRST, chd_pkg::PH_SIZE_MORE: begin
				if (h.ok) begin
					if (phase_q == chd_pkg::PH_SIZE_MORE &&
						remain_q[chd_pkg::SIZE_BITS-1 -: 4] != 4'd0) begin
						err_d   = chd_pkg::ST_OVERFLOW;
						phase_d = chd_pkg::PH_HALT;
					end else if (phase_q == chd_pkg::PH_SIZE_FIRST) begin
						remain_d = {{(chd_pkg::SIZE_BITS - 4){1'b0}}, h.val};
						phase_d  = chd_pkg::PH_SIZE_MORE;
					end else begin
						remain_d = {remain_q[chd_pkg::SIZE_BITS-5:0], h.val};
					end
				end else if (phase_q == chd_pkg::PH_SIZE_FIRST) begin
					err_d   = chd_pkg::ST_FRAMING;
					phase_d = chd_pkg::PH_HALT;
				end else if (ctl.data == chd_pkg::BYTE_CR) begin
					phase_d = chd_pkg::PH_SIZE_LF;
				end else begin
					phase_d = chd_pkg::PH_SIZE_EXT;
				end
			end
			chd_pkg::PH_SIZE_EXT: begin
				if (ctl.data == chd_pkg::BYTE_CR) begin
					phase_d = chd_pkg::PH_SIZE_LF;
				end
			end
			chd_pkg::PH_SIZE_LF: begin
				if (ctl.data != chd_pkg::BYTE_LF) begin
					err_d   = chd_pkg::ST_FRAMING;
					phase_d = chd_pkg::PH_HALT;
				end else if (remain_q == '0) begin
					phase_d = chd_pkg::PH_END_CR;
				end else begin
					phase_d = chd_pkg::PH_DATA;
				end
			end
			chd_pkg::PH_DATA: begin
				ob       = ctl.data;
				pv       = 1'b1;
				remain_d = remain_q - 1'b1;
				if (total_q != '1) begin
					total_d = total_q + 1'b1;
				end
				if (remain_q == {{(chd_pkg::SIZE_BITS - 1){1'b0}}, 1'b1}) begin
					phase_d = chd_pkg::PH_DATA_CR;
				end
			end
			chd_pkg::PH_DATA_CR, chd_pkg::PH_END_CR: begin
				if (ctl.data == chd_pkg::BYTE_CR) begin
					phase_d = (phase_q == chd_pkg::PH_DATA_CR) ?
						chd_pkg::PH_DATA_LF : chd_pkg::PH_END_LF;
				end else begin
					err_d   = chd_pkg::ST_FRAMING;
					phase_d = chd_pkg::PH_HALT;
				end
			end
			chd_pkg::PH_DATA_LF: begin
				if (ctl.data != chd_pkg::BYTE_LF) begin
					err_d   = chd_pkg::ST_FRAMING;
					phase_d = chd_pkg::PH_HALT;
				end else if (too_large) begin
					err_d   = chd_pkg::ST_TOO_LARGE;
					phase_d = chd_pkg::PH_HALT;
				end else begin
					phase_d = chd_pkg::PH_SIZE_FIRST;
				end
			end
			chd_pkg::PH_END_LF: begin
				if (ctl.data == chd_pkg::BYTE_LF) begin
					fin_d   = 1'b1;
					phase_d = chd_pkg::PH_DONE;
				end else begin
					err_d   = chd_pkg::ST_FRAMING;
					phase_d = chd_pkg::PH_HALT;
				end
			end
			chd_pkg::PH_DONE: begin
				err_d   = chd_pkg::ST_AFTER_END;
				phase_d = chd_pkg::PH_HALT;
			end
			default: begin
				phase_d = chd_pkg::PH_HALT;
			end
		endcase
	end

	// Advance the decoder state once per stepped byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= chd_pkg::PH_SIZE_FIRST;
			err_q    <= chd_pkg::ST_OK;
			fin_q    <= 1'b0;
			remain_q <= '0;
			total_q  <= '0;
		end else if (ctl.step) begin
			phase_q  <= phase_d;
			err_q    <= err_d;
			fin_q    <= fin_d;
			remain_q <= remain_d;
			total_q  <= total_d;
		end
	end

	assign res.out_byte      = ob;
	assign res.payload_valid = pv;
	assign res.body_done     = fin_d;
	assign res.status        = err_d;

	assign stat.err   = err_q;
	assign stat.fin   = fin_q;
	assign stat.phase = phase_q;

endmodule

// ===== rtl/http_chunked_body_decoder.sv =====
// Channel | Role   | Payload                                   | Handshake
// raw     | sink   | in_byte[7:0]                              | valid / ready
// dec     | source | out_byte, payload_valid, body_done, status | valid / ready
// apb     | slave  | max_body_size at byte address 0           | psel / penable
//
// One result per raw byte. A byte is held in the input register until it is stepped,
// and its result is then loaded into the output register.
// Throughput is one byte per cycle while dec accepts results, set by the combinational framing step.
// With dec stalled the input register takes at most one more byte, then raw.ready drops.
// arst_n clears the decoder state, the limit and both valid flags at once.
`include "assert_macros.svh"

module http_chunked_body_decoder (
	input  logic                           clk,
	input  logic                           arst_n,
	chd_raw_if.sink                        raw,
	chd_dec_if.source                      dec,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [chd_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [chd_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [chd_pkg::CFG_DATA_W-1:0] prdata,
	output logic                           pready
);

	logic                      valid_s1;
	logic [7:0]                byte_s1;
	logic                      advance;
	logic                      res_valid_q;
	chd_pkg::res_t             res_q;
	chd_pkg::res_t             res;
	chd_pkg::step_t            ctl;
	chd_pkg::frame_stat_t      stat;
	logic [chd_pkg::MAX_W-1:0] max_body_size;

	chd_apb u_apb (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.max_body_size (max_body_size)
	);

	// Step the byte in hand when the output register is free or draining
	assign advance   = valid_s1 && (!res_valid_q || dec.ready);
	assign raw.ready = !valid_s1 || advance;
	assign ctl.step  = advance;
	assign ctl.data  = byte_s1;

	chd_frame u_frame (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.max_body_size (max_body_size),
		.res           (res),
		.stat          (stat)
	);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (raw.valid && raw.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (raw.valid && raw.ready) begin
			byte_s1 <= raw.in_byte;
		end
	end

	// Result register: load on advance, drop once transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (dec.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign dec.valid         = res_valid_q;
	assign dec.out_byte      = res_q.out_byte;
	assign dec.payload_valid = res_q.payload_valid;
	assign dec.body_done     = res_q.body_done;
	assign dec.status        = res_q.status;

	`CHD_ASSERT_NOW(a_no_payload_on_error, clk, arst_n,
		dec.valid && dec.status != chd_pkg::ST_OK, !dec.payload_valid,
		"payload passed out with an error status")
	`CHD_ASSERT_NOW(a_no_payload_after_done, clk, arst_n,
		dec.valid && dec.payload_valid, !dec.body_done,
		"payload passed out after end of body")
	`CHD_ASSERT_NEXT(a_error_sticky, clk, arst_n,
		stat.err != chd_pkg::ST_OK,
		stat.err == $past(stat.err) && stat.phase == chd_pkg::PH_HALT,
		"error code changed after being raised")
	`CHD_ASSERT_NOW(a_ready_when_empty, clk, arst_n,
		!valid_s1, raw.ready,
		"input stalled with an empty input register")

endmodule
